// ===== rtl/mrtl_pkg.sv =====
// Package with the shared types and constants of the traffic light controller.
`timescale 1ns / 1ps

package mrtl_pkg;

  localparam int ROAD_SLOTS = 8;
  localparam int ROAD_IDX_W = 3;
  localparam int COUNT_W    = 4;
  localparam int SENSOR_W   = 8;
  localparam int PHASE_W    = 3;
  localparam int PHASES_W   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [PHASE_W-1:0] {
    PH_STOP       = 3'd0,
    PH_GO_DELAY   = 3'd1,
    PH_GO         = 3'd2,
    PH_STOP_DELAY = 3'd3,
    PH_WARNING    = 3'd4,
    PH_STOPPING   = 3'd5
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROAD_COUNT    = 3'd0,
    CFG_GO_DELAY      = 3'd1,
    CFG_STOP_DELAY    = 3'd2,
    CFG_WARNING_TIME  = 3'd3,
    CFG_STOPPING_TIME = 3'd4
  } cfg_reg_t;

  localparam logic [COUNT_W-1:0]    RST_ROAD_COUNT    = 4'd4;
  localparam logic [CFG_DATA_W-1:0] RST_GO_DELAY      = 8'd22;
  localparam logic [CFG_DATA_W-1:0] RST_STOP_DELAY    = 8'd15;
  localparam logic [CFG_DATA_W-1:0] RST_WARNING_TIME  = 8'd5;
  localparam logic [CFG_DATA_W-1:0] RST_STOPPING_TIME = 8'd2;
  localparam logic [COUNT_W-1:0]    MIN_ROADS         = 4'd2;

  typedef struct packed {
    logic step;
    logic in_use;
    logic go;
    logic stop;
  } road_ctrl_t;

  typedef struct packed {
    logic                  hit;
    logic [ROAD_IDX_W-1:0] first;
    logic [ROAD_IDX_W-1:0] second;
  } pair_sel_t;

endpackage

// ===== rtl/mrtl_if.sv =====
// Channel interfaces for sensor ticks, light results and configuration writes.
`timescale 1ns / 1ps

interface mrtl_in_if;
  import mrtl_pkg::*;
  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] sensor_bits;
  modport source (output valid, output sensor_bits, input ready);
  modport sink (input valid, input sensor_bits, output ready);
endinterface

interface mrtl_out_if;
  import mrtl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [PHASES_W-1:0]   light_phases;
  logic                  pair_valid;
  logic [ROAD_IDX_W-1:0] pair_first;
  logic [ROAD_IDX_W-1:0] pair_second;
  logic                  switched;
  modport source (output valid, output light_phases, output pair_valid, output pair_first,
                  output pair_second, output switched, input ready);
  modport sink (input valid, input light_phases, input pair_valid, input pair_first,
                input pair_second, input switched, output ready);
endinterface

interface mrtl_cfg_if;
  import mrtl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/mrtl_pair_select.sv =====
// Priority search for the next served road pair and its opposite road.
`timescale 1ns / 1ps

module mrtl_pair_select (
  input  logic [mrtl_pkg::SENSOR_W-1:0]   sensor_bits,
  input  logic [mrtl_pkg::COUNT_W-1:0]    road_num,
  input  logic                            pair_set,
  input  logic [mrtl_pkg::ROAD_IDX_W-1:0] pair_a,
  input  logic [mrtl_pkg::ROAD_IDX_W-1:0] pair_b,
  output mrtl_pkg::pair_sel_t             sel
);
  import mrtl_pkg::*;

  logic                  hit;
  logic [ROAD_IDX_W-1:0] first;
  logic [COUNT_W-1:0]    sum;

  always_comb begin
    hit   = 1'b0;
    first = '0;
    for (int i = ROAD_SLOTS - 1; i >= 0; i--) begin
      if ((COUNT_W'(i) < road_num) && sensor_bits[i] &&
          !(pair_set && ((ROAD_IDX_W'(i) == pair_a) || (ROAD_IDX_W'(i) == pair_b)))) begin
        hit   = 1'b1;
        first = ROAD_IDX_W'(i);
      end
    end
  end

  // The sum stays below twice the road count, so one subtraction wraps it.
  assign sum = {1'b0, first} + (road_num >> 1);

  always_comb begin
    sel.hit    = hit;
    sel.first  = first;
    sel.second = (sum >= road_num) ? ROAD_IDX_W'(sum - road_num) : ROAD_IDX_W'(sum);
  end

endmodule

// ===== rtl/mrtl_road.sv =====
// Light phase sequencer and countdown timer of one road.
`timescale 1ns / 1ps

module mrtl_road #(
  parameter int TIMER_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mrtl_pkg::road_ctrl_t   ctrl,
  input  logic [TIMER_BITS-1:0]  go_load,
  input  logic [TIMER_BITS-1:0]  stop_load,
  input  logic [TIMER_BITS-1:0]  warn_load,
  input  logic [TIMER_BITS-1:0]  stopping_load,
  output mrtl_pkg::phase_t       phase_nxt_o
);
  import mrtl_pkg::*;

  phase_t                phase_r;
  phase_t                phase_nxt;
  logic [TIMER_BITS-1:0] cnt_r;
  logic [TIMER_BITS-1:0] cnt_nxt;
  logic [TIMER_BITS-1:0] cnt_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_STOP;
      cnt_r   <= '0;
    end else if (ctrl.step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // The countdown drops first, then the phase step looks at the new value.
  assign cnt_dec = (cnt_r != '0) ? cnt_r - 1'b1 : '0;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_dec;
    if (!ctrl.in_use) begin
      phase_nxt = PH_STOP;
      cnt_nxt   = '0;
    end else begin
      case (phase_r)
        PH_STOP: begin
          if (ctrl.go) begin
            phase_nxt = PH_GO_DELAY;
            cnt_nxt   = go_load;
          end
        end
        PH_GO_DELAY: begin
          if (cnt_dec == '0) phase_nxt = PH_GO;
        end
        PH_GO: begin
          if (ctrl.stop) begin
            phase_nxt = PH_STOP_DELAY;
            cnt_nxt   = stop_load;
          end
        end
        PH_STOP_DELAY: begin
          if (cnt_dec == '0) begin
            phase_nxt = PH_WARNING;
            cnt_nxt   = warn_load;
          end
        end
        PH_WARNING: begin
          if (cnt_dec == '0) begin
            phase_nxt = PH_STOPPING;
            cnt_nxt   = stopping_load;
          end
        end
        PH_STOPPING: begin
          if (cnt_dec == '0) phase_nxt = PH_STOP;
        end
        default: begin
          phase_nxt = PH_STOP;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  assign phase_nxt_o = phase_nxt;

endmodule

// ===== rtl/multi_road_traffic_light_controller_core.sv =====
// Top level of the multi-road traffic light controller.
// Each item on the in_ch channel is one tick carrying a sensor bit per road.
// For every accepted item exactly one item leaves on out_ch: the light phase
// of every road after that tick, the served pair and whether it changed.
// Configuration writes arrive on cfg_ch, which is always ready; the user must
// make them only while no tick is in flight, as the block does not enforce it.
// An accepted tick waits in the input register until the output register is
// empty or being read; its result is then loaded into the output register and
// offered on out_ch. The block takes one item per cycle while out_ch is not
// stalled, with a single pass of pair search and phase update between the input
// register and the output register.
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more item before in_ch drops ready.
// Reset restores the default configuration, puts every road at stop with a
// zero countdown, clears the served pair and empties both registers.
`timescale 1ns / 1ps

module multi_road_traffic_light_controller_core #(
  parameter int MAX_ROADS  = 8,
  parameter int TIMER_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  mrtl_in_if.sink     in_ch,
  mrtl_out_if.source  out_ch,
  mrtl_cfg_if.sink    cfg_ch
);
  import mrtl_pkg::*;

  localparam int ROAD_LIMIT = (MAX_ROADS < ROAD_SLOTS) ? MAX_ROADS : ROAD_SLOTS;
  localparam logic [COUNT_W-1:0]    ROAD_LIMIT_C = COUNT_W'(ROAD_LIMIT);
  localparam logic [TIMER_BITS-1:0] TIMER_MAX    = '1;

  function automatic logic [TIMER_BITS-1:0] sat_load(input logic [CFG_DATA_W-1:0] v);
    logic [TIMER_BITS-1:0] res;
    if (32'(v) > 32'(TIMER_MAX)) res = TIMER_MAX;
    else res = TIMER_BITS'(v);
    return res;
  endfunction

  logic [COUNT_W-1:0]    road_count_r;
  logic [CFG_DATA_W-1:0] go_delay_r;
  logic [CFG_DATA_W-1:0] stop_delay_r;
  logic [CFG_DATA_W-1:0] warning_time_r;
  logic [CFG_DATA_W-1:0] stopping_time_r;

  logic                  s1_valid_r;
  logic [SENSOR_W-1:0]   s1_sensor_r;

  logic                  pair_set_r;
  logic [ROAD_IDX_W-1:0] pair_a_r;
  logic [ROAD_IDX_W-1:0] pair_b_r;

  logic                  out_valid_r;
  logic [PHASES_W-1:0]   phases_r;
  logic                  pair_valid_r;
  logic [ROAD_IDX_W-1:0] first_r;
  logic [ROAD_IDX_W-1:0] second_r;
  logic                  switched_r;

  logic                  commit;
  logic [COUNT_W-1:0]    road_num;
  pair_sel_t             sel;
  logic [PHASES_W-1:0]   phases_nxt;
  phase_t                road_phase_nxt [ROAD_LIMIT];
  logic [TIMER_BITS-1:0] go_load;
  logic [TIMER_BITS-1:0] stop_load;
  logic [TIMER_BITS-1:0] warn_load;
  logic [TIMER_BITS-1:0] stopping_load;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      road_count_r    <= RST_ROAD_COUNT;
      go_delay_r      <= RST_GO_DELAY;
      stop_delay_r    <= RST_STOP_DELAY;
      warning_time_r  <= RST_WARNING_TIME;
      stopping_time_r <= RST_STOPPING_TIME;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        CFG_ROAD_COUNT:    road_count_r    <= cfg_ch.data[COUNT_W-1:0];
        CFG_GO_DELAY:      go_delay_r      <= cfg_ch.data;
        CFG_STOP_DELAY:    stop_delay_r    <= cfg_ch.data;
        CFG_WARNING_TIME:  warning_time_r  <= cfg_ch.data;
        CFG_STOPPING_TIME: stopping_time_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (road_count_r < MIN_ROADS) road_num = MIN_ROADS;
    else if (road_count_r > ROAD_LIMIT_C) road_num = ROAD_LIMIT_C;
    else road_num = road_count_r;
  end

  assign go_load       = sat_load(go_delay_r);
  assign stop_load     = sat_load(stop_delay_r);
  assign warn_load     = sat_load(warning_time_r);
  assign stopping_load = sat_load(stopping_time_r);

  assign commit      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || commit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (commit) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) s1_sensor_r <= in_ch.sensor_bits;
  end

  mrtl_pair_select u_pair_select (
    .sensor_bits (s1_sensor_r),
    .road_num    (road_num),
    .pair_set    (pair_set_r),
    .pair_a      (pair_a_r),
    .pair_b      (pair_b_r),
    .sel         (sel)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_set_r <= 1'b0;
      pair_a_r   <= '0;
      pair_b_r   <= '0;
    end else if (commit && sel.hit) begin
      pair_set_r <= 1'b1;
      pair_a_r   <= sel.first;
      pair_b_r   <= sel.second;
    end
  end

  for (genvar r = 0; r < ROAD_SLOTS; r++) begin : g_road
    if (r < ROAD_LIMIT) begin : g_used
      road_ctrl_t ctrl;
      logic       target;

      assign target      = (ROAD_IDX_W'(r) == sel.first) || (ROAD_IDX_W'(r) == sel.second);
      assign ctrl.step   = commit;
      assign ctrl.in_use = COUNT_W'(r) < road_num;
      assign ctrl.go     = sel.hit && target;
      assign ctrl.stop   = sel.hit && !target;

      mrtl_road #(
        .TIMER_BITS (TIMER_BITS)
      ) u_road (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .go_load       (go_load),
        .stop_load     (stop_load),
        .warn_load     (warn_load),
        .stopping_load (stopping_load),
        .phase_nxt_o   (road_phase_nxt[r])
      );

      assign phases_nxt[PHASE_W*r +: PHASE_W] = road_phase_nxt[r];
    end else begin : g_absent
      assign phases_nxt[PHASE_W*r +: PHASE_W] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      phases_r     <= phases_nxt;
      pair_valid_r <= pair_set_r || sel.hit;
      first_r      <= sel.hit ? sel.first : pair_a_r;
      second_r     <= sel.hit ? sel.second : pair_b_r;
      switched_r   <= sel.hit;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.light_phases = phases_r;
  assign out_ch.pair_valid   = pair_valid_r;
  assign out_ch.pair_first   = first_r;
  assign out_ch.pair_second  = second_r;
  assign out_ch.switched     = switched_r;

  a_pair_kept: assert property (@(posedge clk) disable iff (!rst_n)
    commit && sel.hit |=> pair_set_r && (pair_a_r != pair_b_r))
    else $error("served pair not stored after a switch");

  a_switch_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.switched |-> out_ch.pair_valid &&
      (out_ch.pair_first != out_ch.pair_second))
    else $error("switched result without a proper pair");

  a_tick_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !commit |=> s1_valid_r && $stable(s1_sensor_r))
    else $error("waiting tick lost from the input register");

endmodule
